FILE: src/butterworth_tone_control_unit_macros.svh
// Assertion macros shared by the checker of the tone control unit.
// Every property is clocked on clk_i and is switched off while rst_ni is low.
`ifndef BUTTERWORTH_TONE_CONTROL_UNIT_MACROS_SVH
`define BUTTERWORTH_TONE_CONTROL_UNIT_MACROS_SVH

// The condition must hold at every clock edge.
`define BTC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// When the trigger holds, the consequence must hold at the next clock edge.
`define BTC_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types, sizes and build-time filter coefficients for the
// Butterworth tone control unit.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int CHANNELS    = 2;
  localparam int SECTIONS    = 4;
  localparam int SAMPLE_BITS = 24;
  localparam int SET_BITS    = 17;
  localparam int STATE_BITS  = 40;
  localparam int EXTRA_FRAC  = 4;

  // Serial multiplier operands: a parallel coefficient and a serial operand.
  localparam int COEF_BITS = 34;
  localparam int MUL_BITS  = 44;
  localparam int PROD_BITS = COEF_BITS + MUL_BITS;
  localparam int CNT_W     = $clog2(MUL_BITS);
  localparam int QOUT_BITS = 48;
  localparam int WIDE_BITS = 52;
  localparam int MIX_BITS  = 60;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SEC_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int ADDR_W = CH_W + SEC_W + 2;
  localparam int DEPTH  = 1 << ADDR_W;

  localparam longint unsigned Q30_ONE    = 64'd1073741824;
  localparam longint unsigned PI_Q30     = 64'd3373259426;
  localparam longint unsigned TAN_LP_Q30 = 64'd314523858;
  localparam longint unsigned TAN_HP_Q30 = 64'd688088445;

  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef coef_t                        coef_tab_t [SECTIONS];
  typedef logic signed [STATE_BITS-1:0] state_t;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_BASS   = 2'd1,
    REG_TREBLE = 2'd2
  } reg_idx_e;

  // Request to the serial multiplier.
  typedef struct packed {
    logic                        start;
    coef_t                       mcand;
    logic signed [MUL_BITS-1:0]  mplier;
  } mul_req_t;

  // Request to the delay line store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    state_t            wdata;
    logic [ADDR_W-1:0] raddr;
    logic              clr;
    logic [CH_W-1:0]   clr_ch;
  } dly_req_t;

  // Q30 product rounded half up.
  function automatic longint unsigned umulq(longint unsigned a, longint unsigned b);
    return (a * b + (Q30_ONE >> 1)) >> 30;
  endfunction

  // Unsigned restoring division, used only while building the coefficients.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int bi = 63; bi >= 0; bi--) begin
      r = {r[62:0], n[bi]};
      if (r >= d) begin
        r     = r - d;
        q[bi] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 sine by a Taylor series.
  function automatic longint unsigned sin_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x2   = umulq(x, x);
    term = x;
    sum  = x;
    for (int k = 1; k <= 7; k++) begin
      term = udiv(umulq(term, x2), longint'((2 * k) * (2 * k + 1)));
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // One coefficient column for all sections: sel 0 gives A, 1 gives d1, 2 gives d2.
  function automatic coef_tab_t make_tab(bit low, int sel);
    coef_tab_t       tab;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned theta;
    longint unsigned twoar;
    longint unsigned s;
    longint unsigned num;
    longint          val;
    a = low ? TAN_LP_Q30 : TAN_HP_Q30;
    for (int i = 0; i < SECTIONS; i++) begin
      a2    = umulq(a, a);
      theta = udiv(PI_Q30 * longint'(2 * i + 1) + longint'(2 * SECTIONS),
                   longint'(4 * SECTIONS));
      twoar = umulq(2 * a, sin_q30(theta));
      s     = a2 + twoar + Q30_ONE;
      num   = low ? a2 : Q30_ONE;
      if (sel == 0) begin
        val = longint'(udiv((num << 30) + (s >> 1), s));
      end else if (sel == 1) begin
        val = longint'(udiv(((2 * (Q30_ONE - a2)) << 30) + (s >> 1), s));
      end else begin
        val = -longint'(udiv(((a2 + Q30_ONE - twoar) << 30) + (s >> 1), s));
      end
      tab[i] = COEF_BITS'(val);
    end
    return tab;
  endfunction

  localparam coef_tab_t LP_A  = make_tab(1'b1, 0);
  localparam coef_tab_t LP_D1 = make_tab(1'b1, 1);
  localparam coef_tab_t LP_D2 = make_tab(1'b1, 2);
  localparam coef_tab_t HP_A  = make_tab(1'b0, 0);
  localparam coef_tab_t HP_D1 = make_tab(1'b0, 1);
  localparam coef_tab_t HP_D2 = make_tab(1'b0, 2);

  // Product divided by 2^30, rounded half up.
  function automatic logic signed [QOUT_BITS-1:0] qround(logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0] t;
    t = p + (PROD_BITS'(1) <<< 29);
    return QOUT_BITS'(t >>> 30);
  endfunction

  // Saturation to the delay line format.
  function automatic state_t sat_state(logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = (WIDE_BITS'(1) <<< (STATE_BITS - 1)) - WIDE_BITS'(1);
    lo = -hi - WIDE_BITS'(1);
    if (v > hi) begin
      return STATE_BITS'(hi);
    end else if (v < lo) begin
      return STATE_BITS'(lo);
    end
    return STATE_BITS'(v);
  endfunction

endpackage

FILE: src/btc_sermul.sv
// ----------------------------------------------------------------------------
// btc_sermul
// Serial-parallel signed multiplier: the coefficient stays parallel, the
// other operand is shifted in one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module btc_sermul (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  btc_pkg::mul_req_t                         req_i,
  output logic                                      done_o,
  output logic signed [btc_pkg::PROD_BITS-1:0]      prod_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [btc_pkg::CNT_W-1:0]          cnt_q, cnt_d;
  btc_pkg::coef_t                     a_q, a_d;
  logic [btc_pkg::MUL_BITS-1:0]       b_q, b_d;
  logic signed [btc_pkg::COEF_BITS:0] acc_q, acc_d;
  logic [btc_pkg::MUL_BITS-1:0]       lo_q, lo_d;

  logic                               last;
  logic signed [btc_pkg::COEF_BITS:0] aext;
  logic signed [btc_pkg::COEF_BITS:0] addend;
  logic signed [btc_pkg::COEF_BITS:0] sum;
  logic [btc_pkg::COEF_BITS+btc_pkg::MUL_BITS:0] full;

  // The top bit of the serial operand carries negative weight.
  assign last   = (cnt_q == btc_pkg::CNT_W'(btc_pkg::MUL_BITS - 1));
  assign aext   = (btc_pkg::COEF_BITS + 1)'(a_q);
  assign addend = b_q[0] ? (last ? -aext : aext) : '0;
  assign sum    = acc_q + addend;

  // Next state of the shift-add datapath.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    lo_d   = lo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = req_i.mcand;
      b_d    = req_i.mplier;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = sum >>> 1;
      lo_d  = {sum[0], lo_q[btc_pkg::MUL_BITS-1:1]};
      b_d   = b_q >> 1;
      cnt_d = cnt_q + btc_pkg::CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial product registers.
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    lo_q  <= lo_d;
  end

  assign full   = {acc_q, lo_q};
  assign done_o = done_q;
  assign prod_o = $signed(full[btc_pkg::PROD_BITS-1:0]);

endmodule

FILE: src/btc_dly_ram.sv
// ----------------------------------------------------------------------------
// btc_dly_ram
// Delay line store for both filters and all channels, with one valid bit
// per entry so that reset and restart read back as zero.
// ----------------------------------------------------------------------------
module btc_dly_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  btc_pkg::dly_req_t req_i,
  output btc_pkg::state_t   rdata_o
);

  btc_pkg::state_t             mem_q [btc_pkg::DEPTH];
  logic [btc_pkg::DEPTH-1:0]   vld_q, vld_d;
  btc_pkg::state_t             rdata_q;
  logic                        rvld_q;

  // Restart clears one channel's entries; a write marks its entry valid.
  always_comb begin
    logic [btc_pkg::ADDR_W-1:0] ea;
    vld_d = vld_q;
    for (int e = 0; e < btc_pkg::DEPTH; e++) begin
      ea = btc_pkg::ADDR_W'(e);
      if (req_i.clr && (ea[btc_pkg::SEC_W+1 +: btc_pkg::CH_W] == req_i.clr_ch)) begin
        vld_d[e] = 1'b0;
      end
    end
    if (req_i.we) begin
      vld_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      rvld_q <= vld_q[req_i.raddr];
    end
  end

  // Storage with one write port and a registered read port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

FILE: src/butterworth_tone_control_unit.sv
// ----------------------------------------------------------------------------
// butterworth_tone_control_unit
// Two-channel tone control: 8th-order Butterworth low-pass (4 kHz) and
// high-pass (8 kHz) branches mixed with bass, treble and gain settings.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | channel_index_i, restart_i, sample_in_i
//   out     | output    | out_valid_o/out_stall_i | channel_out_o, sample_out_o
//   config  | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// The beat time is set by the bit-serial multiplier, which forms all 27
// products one after the other.
// A new input beat is taken only when the previous one has left the datapath;
// it may be taken while a result still waits in the output register.
// Reset clears all delay lines at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module butterworth_tone_control_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample input
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  channel_index_i,
  input  logic                                  restart_i,
  input  logic signed [btc_pkg::SAMPLE_BITS-1:0] sample_in_i,
  // Sample output
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  channel_out_o,
  output logic signed [btc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  // Configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_RD1  = 12'b000000000010,
    S_RD2  = 12'b000000000100,
    S_CAP  = 12'b000000001000,
    S_M1   = 12'b000000010000,
    S_M2   = 12'b000000100000,
    S_WR   = 12'b000001000000,
    S_MA   = 12'b000010000000,
    S_MIXL = 12'b000100000000,
    S_MIXH = 12'b001000000000,
    S_GAIN = 12'b010000000000,
    S_DONE = 12'b100000000000
  } state_e;

  localparam logic [btc_pkg::SET_BITS-1:0] SET_RESET = btc_pkg::SET_BITS'(32768);

  state_e                               state_q, state_d;
  logic                                 filt_q, filt_d;
  logic [btc_pkg::SEC_W-1:0]            sec_q, sec_d;
  logic [btc_pkg::CH_W-1:0]             ch_q, ch_d;
  logic                                 chin_q, chin_d;
  logic signed [btc_pkg::MUL_BITS-1:0]  xs_q, xs_d;
  btc_pkg::state_t                      x_q, x_d;
  btc_pkg::state_t                      w1_q, w1_d;
  btc_pkg::state_t                      w2_q, w2_d;
  btc_pkg::state_t                      w0_q, w0_d;
  btc_pkg::state_t                      lp_q, lp_d;
  btc_pkg::state_t                      hp_q, hp_d;
  logic signed [btc_pkg::QOUT_BITS-1:0] t_q, t_d;
  logic signed [btc_pkg::MIX_BITS-1:0]  mix_q, mix_d;
  logic signed [btc_pkg::SAMPLE_BITS-1:0] res_q, res_d;
  logic                                 out_valid_q, out_valid_d;
  logic                                 out_ch_q, out_ch_d;
  logic signed [btc_pkg::SAMPLE_BITS-1:0] out_smp_q, out_smp_d;
  logic [btc_pkg::SET_BITS-1:0]         gain_q, bass_q, treble_q;

  btc_pkg::mul_req_t                    mul_req;
  logic                                 mul_done;
  logic signed [btc_pkg::PROD_BITS-1:0] prod;
  btc_pkg::dly_req_t                    dly_req;
  btc_pkg::state_t                      rd_data;

  btc_pkg::coef_t                       c_a, c_d1, c_d2;
  logic [btc_pkg::ADDR_W-1:0]           base_addr;
  logic signed [btc_pkg::QOUT_BITS-1:0] rp;
  logic signed [btc_pkg::WIDE_BITS-1:0] w0_sum;
  logic signed [btc_pkg::MUL_BITS-1:0]  tap_sum;
  logic signed [17:0]                   w_bass, w_treble;
  logic signed [btc_pkg::MIX_BITS-1:0]  mix_sum;
  logic signed [btc_pkg::MIX_BITS-1:0]  mix_rnd;
  logic signed [btc_pkg::PROD_BITS-1:0] g_rnd;
  logic signed [btc_pkg::PROD_BITS-1:0] smax;
  logic                                 cfg_wr;
  logic                                 out_take;

  btc_sermul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  btc_dly_ram u_dly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dly_req),
    .rdata_o (rd_data)
  );

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= SET_RESET;
      bass_q   <= SET_RESET;
      treble_q <= SET_RESET;
    end else if (cfg_wr) begin
      case (btc_pkg::reg_idx_e'(paddr[3:2]))
        btc_pkg::REG_GAIN:   gain_q   <= pwdata[btc_pkg::SET_BITS-1:0];
        btc_pkg::REG_BASS:   bass_q   <= pwdata[btc_pkg::SET_BITS-1:0];
        btc_pkg::REG_TREBLE: treble_q <= pwdata[btc_pkg::SET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (btc_pkg::reg_idx_e'(paddr[3:2]))
      btc_pkg::REG_GAIN:   prdata = 32'(gain_q);
      btc_pkg::REG_BASS:   prdata = 32'(bass_q);
      btc_pkg::REG_TREBLE: prdata = 32'(treble_q);
      default:             prdata = '0;
    endcase
  end

  // Coefficients of the current section.
  assign c_a  = filt_q ? btc_pkg::HP_A[sec_q]  : btc_pkg::LP_A[sec_q];
  assign c_d1 = filt_q ? btc_pkg::HP_D1[sec_q] : btc_pkg::LP_D1[sec_q];
  assign c_d2 = filt_q ? btc_pkg::HP_D2[sec_q] : btc_pkg::LP_D2[sec_q];

  assign base_addr = {filt_q, ch_q, sec_q, 1'b0};

  // Section arithmetic around the multiplier.
  assign rp      = btc_pkg::qround(prod);
  assign w0_sum  = btc_pkg::WIDE_BITS'(t_q) + btc_pkg::WIDE_BITS'(rp)
                 + btc_pkg::WIDE_BITS'(x_q);
  assign tap_sum = filt_q
                 ? (btc_pkg::MUL_BITS'(w0_q) - (btc_pkg::MUL_BITS'(w1_q) <<< 1)
                    + btc_pkg::MUL_BITS'(w2_q))
                 : (btc_pkg::MUL_BITS'(w0_q) + (btc_pkg::MUL_BITS'(w1_q) <<< 1)
                    + btc_pkg::MUL_BITS'(w2_q));

  // Mix weights in units of 2^-16, and the rounding steps.
  assign w_bass   = $signed({1'b0, bass_q}) - 18'sd32768;
  assign w_treble = $signed({1'b0, treble_q}) - 18'sd32768;
  assign mix_sum  = mix_q + btc_pkg::MIX_BITS'(prod);
  assign mix_rnd  = (mix_sum + (btc_pkg::MIX_BITS'(1) <<< 15)) >>> 16;
  assign g_rnd    = (prod + (btc_pkg::PROD_BITS'(1) <<< (14 + btc_pkg::EXTRA_FRAC)))
                    >>> (15 + btc_pkg::EXTRA_FRAC);
  assign smax     = (btc_pkg::PROD_BITS'(1) <<< (btc_pkg::SAMPLE_BITS - 1))
                    - btc_pkg::PROD_BITS'(1);

  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    filt_d      = filt_q;
    sec_d       = sec_q;
    ch_d        = ch_q;
    chin_d      = chin_q;
    xs_d        = xs_q;
    x_d         = x_q;
    w1_d        = w1_q;
    w2_d        = w2_q;
    w0_d        = w0_q;
    lp_d        = lp_q;
    hp_d        = hp_q;
    t_d         = t_q;
    mix_d       = mix_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_take;
    out_ch_d    = out_ch_q;
    out_smp_d   = out_smp_q;
    mul_req     = '0;
    dly_req     = '0;
    dly_req.clr_ch = ch_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          chin_d = channel_index_i;
          if (32'(channel_index_i) >= btc_pkg::CHANNELS) begin
            ch_d = btc_pkg::CH_W'(btc_pkg::CHANNELS - 1);
          end else begin
            ch_d = btc_pkg::CH_W'(channel_index_i);
          end
          xs_d  = btc_pkg::MUL_BITS'(sample_in_i) <<< btc_pkg::EXTRA_FRAC;
          x_d   = btc_pkg::STATE_BITS'(sample_in_i) <<< btc_pkg::EXTRA_FRAC;
          filt_d = 1'b0;
          sec_d  = '0;
          dly_req.clr    = restart_i;
          dly_req.clr_ch = ch_d;
          state_d = S_RD1;
        end
      end
      S_RD1: begin
        dly_req.raddr = base_addr;
        state_d = S_RD2;
      end
      S_RD2: begin
        w1_d = rd_data;
        dly_req.raddr = base_addr | btc_pkg::ADDR_W'(1);
        state_d = S_CAP;
      end
      S_CAP: begin
        w2_d = rd_data;
        mul_req.start  = 1'b1;
        mul_req.mcand  = c_d1;
        mul_req.mplier = btc_pkg::MUL_BITS'(w1_q);
        state_d = S_M1;
      end
      S_M1: begin
        if (mul_done) begin
          t_d = rp;
          mul_req.start  = 1'b1;
          mul_req.mcand  = c_d2;
          mul_req.mplier = btc_pkg::MUL_BITS'(w2_q);
          state_d = S_M2;
        end
      end
      S_M2: begin
        if (mul_done) begin
          w0_d = btc_pkg::sat_state(w0_sum);
          dly_req.we    = 1'b1;
          dly_req.waddr = base_addr | btc_pkg::ADDR_W'(1);
          dly_req.wdata = w1_q;
          state_d = S_WR;
        end
      end
      S_WR: begin
        dly_req.we    = 1'b1;
        dly_req.waddr = base_addr;
        dly_req.wdata = w0_q;
        mul_req.start  = 1'b1;
        mul_req.mcand  = c_a;
        mul_req.mplier = tap_sum;
        state_d = S_MA;
      end
      S_MA: begin
        if (mul_done) begin
          if (sec_q == btc_pkg::SEC_W'(btc_pkg::SECTIONS - 1)) begin
            sec_d = '0;
            if (!filt_q) begin
              lp_d   = btc_pkg::sat_state(btc_pkg::WIDE_BITS'(rp));
              filt_d = 1'b1;
              x_d    = btc_pkg::STATE_BITS'(xs_q);
              state_d = S_RD1;
            end else begin
              hp_d  = btc_pkg::sat_state(btc_pkg::WIDE_BITS'(rp));
              mix_d = btc_pkg::MIX_BITS'(xs_q) <<< 16;
              mul_req.start  = 1'b1;
              mul_req.mcand  = btc_pkg::COEF_BITS'(w_bass);
              mul_req.mplier = btc_pkg::MUL_BITS'(lp_q);
              state_d = S_MIXL;
            end
          end else begin
            x_d   = btc_pkg::sat_state(btc_pkg::WIDE_BITS'(rp));
            sec_d = sec_q + btc_pkg::SEC_W'(1);
            state_d = S_RD1;
          end
        end
      end
      S_MIXL: begin
        if (mul_done) begin
          mix_d = mix_sum;
          mul_req.start  = 1'b1;
          mul_req.mcand  = btc_pkg::COEF_BITS'(w_treble);
          mul_req.mplier = btc_pkg::MUL_BITS'(hp_q);
          state_d = S_MIXH;
        end
      end
      S_MIXH: begin
        if (mul_done) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = btc_pkg::COEF_BITS'({1'b0, gain_q});
          mul_req.mplier = btc_pkg::MUL_BITS'(mix_rnd);
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        if (mul_done) begin
          if (g_rnd > smax) begin
            res_d = btc_pkg::SAMPLE_BITS'(smax);
          end else if (g_rnd < -smax - btc_pkg::PROD_BITS'(1)) begin
            res_d = btc_pkg::SAMPLE_BITS'(-smax - btc_pkg::PROD_BITS'(1));
          end else begin
            res_d = btc_pkg::SAMPLE_BITS'(g_rnd);
          end
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_take) begin
          out_valid_d = 1'b1;
          out_ch_d    = chin_q;
          out_smp_d   = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filt_q      <= 1'b0;
      sec_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filt_q      <= filt_d;
      sec_q       <= sec_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    chin_q    <= chin_d;
    xs_q      <= xs_d;
    x_q       <= x_d;
    w1_q      <= w1_d;
    w2_q      <= w2_d;
    w0_q      <= w0_d;
    lp_q      <= lp_d;
    hp_q      <= hp_d;
    t_q       <= t_d;
    mix_q     <= mix_d;
    res_q     <= res_d;
    out_ch_q  <= out_ch_d;
    out_smp_q <= out_smp_d;
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = out_ch_q;
  assign sample_out_o  = out_smp_q;

endmodule

FILE: src/btc_checker.sv
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks of the tone control unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "butterworth_tone_control_unit_macros.svh"

module btc_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   channel_out_o,
  input logic signed [btc_pkg::SAMPLE_BITS-1:0] sample_out_o,
  input logic                                   pready
);

  // A held result beat keeps its payload.
  `BTC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sample_out_o) && $stable(channel_out_o))

  // The unit works on one beat at a time.
  `BTC_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

  // No result can appear right after a beat is taken.
  `BTC_ASSERT_NEXT(a_no_instant_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // Configuration accesses never wait.
  `BTC_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind butterworth_tone_control_unit btc_checker u_btc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .channel_out_o (channel_out_o),
  .sample_out_o  (sample_out_o),
  .pready        (pready)
);
